/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the sorter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define SWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sws_pkg.sv */
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants for the signed word sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    // Word moving between neighboring cells, with its valid or occupied flag.
    typedef struct packed {
        logic  vld;
        word_t data;
    } link_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic insert;
        logic shift;
        logic out_valid;
        logic last_out;
        logic overflowed;
    } ctl_t;

endpackage

`default_nettype wire

/* rtl/sws_cell.sv */
// ----------------------------------------------------------------------------
// sws_cell
// One sorting cell: keeps the smaller word, passes the larger one right,
// or shifts the right neighbor's word in while the run is unloaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_cell
    import sws_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  shift,
    input  wire link_t fwd_in,
    input  wire link_t right_in,
    output link_t      fwd_out,
    output link_t      held
);

    logic  occ_reg,      occ_next;
    word_t data_reg,     data_next;
    logic  fwd_vld_reg,  fwd_vld_next;
    word_t fwd_data_reg, fwd_data_next;

    always_comb
    begin
        occ_next      = occ_reg;
        data_next     = data_reg;
        fwd_vld_next  = 1'b0;
        fwd_data_next = fwd_data_reg;
        if (shift)
        begin
            occ_next  = right_in.vld;
            data_next = right_in.data;
        end
        else if (fwd_in.vld)
        begin
            if (!occ_reg)
            begin
                occ_next  = 1'b1;
                data_next = fwd_in.data;
            end
            else if (fwd_in.data < data_reg)
            begin
                // keep the new smaller word, push the old one on
                data_next     = fwd_in.data;
                fwd_vld_next  = 1'b1;
                fwd_data_next = data_reg;
            end
            else
            begin
                fwd_vld_next  = 1'b1;
                fwd_data_next = fwd_in.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end
        else
        begin
            occ_reg     <= occ_next;
            fwd_vld_reg <= fwd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        fwd_data_reg <= fwd_data_next;
    end

    assign fwd_out = '{vld: fwd_vld_reg, data: fwd_data_reg};
    assign held    = '{vld: occ_reg, data: data_reg};

endmodule

`default_nettype wire

/* rtl/sws_ctrl.sv */
// ----------------------------------------------------------------------------
// sws_ctrl
// Run sequencer: counts loaded words, waits for the chain to settle,
// then steps the sorted words out under the receiver's stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sws_ctrl
    import sws_pkg::*;
#(
    parameter int MAX_WORDS = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic is_last,
    input  wire logic out_stall,
    output ctl_t      ctl
);

    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam int DW = $clog2(MAX_WORDS);

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg,   cnt_next;
    logic [DW-1:0]  drain_reg, drain_next;
    logic           ovf_reg,   ovf_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        drain_next     = drain_reg;
        ovf_next       = ovf_reg;
        ctl            = '0;
        ctl.overflowed = ovf_reg;
        case (state_reg)
            ST_LOAD:
            begin
                ctl.in_ready = 1'b1;
                if (in_valid)
                begin
                    if (cnt_reg < CW'(MAX_WORDS))
                    begin
                        ctl.insert = 1'b1;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        drain_next = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                // let the last insertion wave reach its resting cell
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DW'(MAX_WORDS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                ctl.out_valid = 1'b1;
                ctl.last_out  = (cnt_reg == CW'(1));
                if (!out_stall)
                begin
                    ctl.shift = 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            drain_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drain_reg <= drain_next;
            ovf_reg   <= ovf_next;
        end
    end

    `SWS_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= CW'(MAX_WORDS), "word count past capacity")
    `SWS_ASSERT(a_emit_nonempty, clk, rst_n, !ctl.out_valid || cnt_reg != '0, "emit with no words")
    `SWS_ASSERT_NEXT(a_run_end, clk, rst_n, ctl.shift && ctl.last_out, ctl.in_ready && !ovf_reg, "run end did not return to load")

endmodule

`default_nettype wire

/* rtl/signed_word_sorter.sv */
// ----------------------------------------------------------------------------
// signed_word_sorter
// Sorts a run of signed 32-bit words in ascending order on a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, value, is_last) takes one word per
//   cycle while a run loads. is_last marks the final word of the run.
//   At most MAX_WORDS words are kept; further words of the run are dropped
//   and every sorted word of that run carries overflowed.
//   After the last word the chain settles until the longest insertion wave
//   along the cells has come to rest; in_stall stays high from then until
//   the run is fully unloaded.
//   Output channel (out_valid / out_stall, sorted_value, last_out,
//   overflowed) gives the run smallest first, one word per cycle while the
//   receiver does not stall; last_out marks the final word.
//   The first sorted word becomes valid once the chain has settled.
//   A stall holds the current word on the output, the whole chain frozen.
//   Reset empties all cells, clears the counters and opens the input.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module signed_word_sorter
    import sws_pkg::*;
#(
    parameter int MAX_WORDS = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire word_t value,
    input  wire logic  is_last,
    output logic       out_valid,
    input  wire logic  out_stall,
    output word_t      sorted_value,
    output logic       last_out,
    output logic       overflowed
);

    ctl_t  ctl;

    // fwd[i] feeds cell i from the left; held[i] is cell i's stored word.
    link_t fwd  [MAX_WORDS+1];
    link_t held [MAX_WORDS+1];

    sws_ctrl #(
        .MAX_WORDS (MAX_WORDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .is_last   (is_last),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    // Enter new words at the head of the chain; dropped words never enter.
    assign fwd[0]          = '{vld: ctl.insert, data: value};
    // Shift an empty slot in behind the tail while unloading.
    assign held[MAX_WORDS] = '0;

    for (genvar i = 0; i < MAX_WORDS; i++)
    begin : g_cell
        sws_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (ctl.shift),
            .fwd_in   (fwd[i]),
            .right_in (held[i+1]),
            .fwd_out  (fwd[i+1]),
            .held     (held[i])
        );
    end

    // The head cell always holds the smallest remaining word.
    assign in_stall     = !ctl.in_ready;
    assign out_valid    = ctl.out_valid;
    assign sorted_value = held[0].data;
    assign last_out     = ctl.last_out;
    assign overflowed   = ctl.overflowed;

    `SWS_ASSERT(a_tail_no_spill, clk, rst_n, !fwd[MAX_WORDS].vld, "word pushed past tail")
    `SWS_ASSERT(a_head_occupied, clk, rst_n, !out_valid || held[0].vld, "valid on empty head")

endmodule

`default_nettype wire
